/* hdl/ste_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite tile expander package
// Shared types and constants for the sprite tile expander.
// ----------------------------------------------------------------------------
package ste_pkg;

   localparam int WordBits = 16;
   localparam int CodeBits = 13;
   localparam int PalBits = 8;
   localparam int PosBits = 10;
   localparam int PrioBits = 3;
   localparam int RowBits = 3;
   localparam int ColBits = 2;

   // The horizontal offset is -10 + 16 and the vertical one is -30 + 32 + 8.
   localparam logic [8:0] XOffset = 9'd6;
   localparam logic [8:0] YOffset = 9'd10;
   localparam logic [PosBits-1:0] ScreenBias = 10'd8;

   typedef struct packed {
      logic [WordBits-1:0] y_word;
      logic [WordBits-1:0] tile_word;
      logic [WordBits-1:0] attr_word;
      logic [WordBits-1:0] x_word;
   } sprite_type;

   typedef struct packed {
      logic [RowBits-1:0] row;
      logic [ColBits-1:0] col;
   } cell_type;

   typedef struct packed {
      logic [CodeBits-1:0] tile_code;
      logic [PalBits-1:0] palette_sel;
      logic signed [PosBits-1:0] x_pos;
      logic signed [PosBits-1:0] y_pos;
      logic flip_x;
      logic flip_y;
      logic [PrioBits-1:0] draw_priority;
      logic shadow;
      logic opaque;
      logic four_bit_mode;
   } desc_type;

endpackage

/* hdl/ste_req_if.sv */
// ----------------------------------------------------------------------------
// Sprite request channel
// Valid/ready channel that carries one sprite's four attribute words.
// ----------------------------------------------------------------------------
interface ste_req_if;
   logic valid;
   logic ready;
   logic [15:0] y_word;
   logic [15:0] tile_word;
   logic [15:0] attr_word;
   logic [15:0] x_word;

   modport source (output valid, output y_word, output tile_word, output attr_word,
                   output x_word, input ready);
   modport sink (input valid, input y_word, input tile_word, input attr_word,
                 input x_word, output ready);
endinterface

/* hdl/ste_rsp_if.sv */
// ----------------------------------------------------------------------------
// Tile descriptor channel
// Valid/ready channel that carries one 8x8 tile descriptor.
// ----------------------------------------------------------------------------
interface ste_rsp_if;
   logic valid;
   logic ready;
   logic [12:0] tile_code;
   logic [7:0] palette_sel;
   logic signed [9:0] x_pos;
   logic signed [9:0] y_pos;
   logic flip_x;
   logic flip_y;
   logic [2:0] draw_priority;
   logic shadow;
   logic opaque;
   logic four_bit_mode;
   logic last_tile;

   modport source (output valid, output tile_code, output palette_sel, output x_pos,
                   output y_pos, output flip_x, output flip_y, output draw_priority,
                   output shadow, output opaque, output four_bit_mode,
                   output last_tile, input ready);
   modport sink (input valid, input tile_code, input palette_sel, input x_pos,
                 input y_pos, input flip_x, input flip_y, input draw_priority,
                 input shadow, input opaque, input four_bit_mode, input last_tile,
                 output ready);
endinterface

/* hdl/ste_calc.sv */
// ----------------------------------------------------------------------------
// Sprite tile expander descriptor unit
// Computes the tile code, palette and screen position of one grid cell.
// ----------------------------------------------------------------------------
module ste_calc (
   input  ste_pkg::sprite_type sprite,
   input  ste_pkg::cell_type   grid_cell,
   output ste_pkg::desc_type   desc
);
   import ste_pkg::*;

   logic [ColBits-1:0] width_m1;
   logic [RowBits-1:0] height_m1;
   logic [ColBits-1:0] cell_x;
   logic [RowBits-1:0] cell_y;
   logic [8:0] x_wrap;
   logic [8:0] y_wrap;

   always_comb begin
      width_m1 = sprite.attr_word[13:12];
      height_m1 = sprite.y_word[14:12];
      cell_x = sprite.attr_word[15] ? width_m1 - grid_cell.col : grid_cell.col;
      cell_y = sprite.y_word[15] ? height_m1 - grid_cell.row : grid_cell.row;
      x_wrap = sprite.x_word[8:0] + XOffset + {4'b0, cell_x, 3'b0};
      y_wrap = sprite.y_word[8:0] + YOffset + {3'b0, cell_y, 3'b0};

      desc.tile_code = {1'b0, sprite.tile_word[11:0]} + {4'b0, grid_cell.row, 6'b0}
                       + {11'b0, grid_cell.col};
      desc.palette_sel = sprite.attr_word[3]
                         ? {sprite.attr_word[7:4], sprite.attr_word[11:8]}
                         : {4'b0, sprite.attr_word[7:4]};
      desc.x_pos = signed'({1'b0, x_wrap} - ScreenBias);
      desc.y_pos = signed'({1'b0, y_wrap} - ScreenBias);
      desc.flip_x = sprite.attr_word[15];
      desc.flip_y = sprite.y_word[15];
      desc.draw_priority = sprite.attr_word[2:0];
      desc.shadow = sprite.attr_word[14];
      desc.opaque = sprite.tile_word[15];
      desc.four_bit_mode = sprite.attr_word[3];
   end

endmodule

/* hdl/ste_seq.sv */
// ----------------------------------------------------------------------------
// Sprite tile expander sequencer
// Holds the sprite words and walks the grid, rows outer and columns inner.
// ----------------------------------------------------------------------------
module ste_seq (
   input  logic               clock,
   input  logic               reset,
   ste_req_if.sink            req_chan,
   ste_rsp_if.source          rsp_chan,
   output ste_pkg::sprite_type sprite,
   output ste_pkg::cell_type   grid_cell,
   input  ste_pkg::desc_type   desc
);
   import ste_pkg::*;

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   sprite_type sprite_ff, sprite_in;
   cell_type cell_ff, cell_in;
   logic last_cell;

   assign last_cell = (cell_ff.row == sprite_ff.y_word[14:12])
                      && (cell_ff.col == sprite_ff.attr_word[13:12]);

   always_comb begin
      state_in = state_ff;
      sprite_in = sprite_ff;
      cell_in = cell_ff;
      case (state_ff)
         IDLE: begin
            if (req_chan.valid) begin
               sprite_in = '{req_chan.y_word, req_chan.tile_word,
                             req_chan.attr_word, req_chan.x_word};
               cell_in = '0;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (rsp_chan.ready) begin
               if (last_cell) begin
                  state_in = IDLE;
               end else if (cell_ff.col == sprite_ff.attr_word[13:12]) begin
                  cell_in.col = '0;
                  cell_in.row = cell_ff.row + 1'b1;
               end else begin
                  cell_in.col = cell_ff.col + 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      sprite_ff <= sprite_in;
      cell_ff <= cell_in;
   end

   assign req_chan.ready = (state_ff == IDLE);
   assign sprite = sprite_ff;
   assign grid_cell = cell_ff;

   assign rsp_chan.valid = (state_ff == EMIT);
   assign rsp_chan.tile_code = desc.tile_code;
   assign rsp_chan.palette_sel = desc.palette_sel;
   assign rsp_chan.x_pos = desc.x_pos;
   assign rsp_chan.y_pos = desc.y_pos;
   assign rsp_chan.flip_x = desc.flip_x;
   assign rsp_chan.flip_y = desc.flip_y;
   assign rsp_chan.draw_priority = desc.draw_priority;
   assign rsp_chan.shadow = desc.shadow;
   assign rsp_chan.opaque = desc.opaque;
   assign rsp_chan.four_bit_mode = desc.four_bit_mode;
   assign rsp_chan.last_tile = last_cell;

endmodule

/* hdl/sprite_tile_expander_unit.sv */
// ----------------------------------------------------------------------------
// Sprite tile expander
// Expands one sprite into one 8x8 tile descriptor per cell of its grid.
// ----------------------------------------------------------------------------
// Each request carries one sprite's four attribute words. The block then
// emits width times height tile descriptors, grid row 0 first and columns in
// ascending order within a row, with last_tile set on the final one. Descriptors
// come out at one per cycle from the grid counter and the shared descriptor unit
// while the result channel does not stall; a grid is 1 to 4 cells wide and 1 to
// 8 cells high. The block
// takes no new request until the final descriptor has been accepted.
module sprite_tile_expander_unit (
   input  logic      clock,
   input  logic      reset,
   ste_req_if.sink   req_chan,
   ste_rsp_if.source rsp_chan
);
   import ste_pkg::*;

   sprite_type sprite;
   cell_type grid_cell;
   desc_type desc;

   ste_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .sprite    (sprite),
      .grid_cell (grid_cell),
      .desc      (desc)
   );

   ste_calc u_calc (
      .sprite    (sprite),
      .grid_cell (grid_cell),
      .desc      (desc)
   );

endmodule
